FILE: rtl/svp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_pkg
// shared types, fixed-point constants and tables of the vapor pressure core
// ----------------------------------------------------------------------------
package svp_pkg;

  localparam int TEMP_FRAC_BITS_DEF  = 8;
  localparam int PRESS_FRAC_BITS_DEF = 16;

  localparam int QUEUE_DEPTH = 2;

  // bit-serial divider geometry
  localparam int DIV_NUM_W = 60;
  localparam int DIV_DEN_W = 34;
  localparam int DIV_QUO_W = 28;

  localparam longint unsigned ONE24 = 64'd16777216;

  // formula constants, q24, rounded to nearest
  localparam logic [26:0]        K_A   = 27'((64'd61121 * ONE24 + 64'd5000) / 64'd10000);
  localparam logic signed [31:0] K_B   = 32'((64'd18678 * ONE24 + 64'd500) / 64'd1000);
  localparam logic [33:0]        K_C   = 34'((64'd25714 * ONE24 + 64'd50) / 64'd100);
  localparam logic [26:0]        K_AA  = 27'((64'd6112 * ONE24 + 64'd500) / 64'd1000);
  localparam logic [28:0]        K_BB  = 29'((64'd1762 * ONE24 + 64'd50) / 64'd100);
  localparam logic [33:0]        K_CC  = 34'((64'd24312 * ONE24 + 64'd50) / 64'd100);
  localparam logic [23:0]        K_LN2 = 24'd11629080;

  // reciprocals for the constant divisions, exact floor for the operand ranges
  // ceil(2^41 / 469), operand below 2^32, quotient in bits 64:41
  localparam logic [32:0] K_F_RCP   = 33'(((64'd1 << 41) + 64'd468) / 64'd469);
  // ceil(2^52 / ln 2 in q24), operand below 2^28, quotient in bits 56:52
  localparam logic [28:0] K_LN2_RCP = 29'(((64'd1 << 52) + 64'd11629079) / 64'd11629080);

  // range limits in q24, inclusive
  localparam logic signed [39:0] BUCK_LO = -40'sd80 * 40'sd16777216;
  localparam logic signed [39:0] BUCK_HI =  40'sd50 * 40'sd16777216;
  localparam logic signed [39:0] MAG_LO  = -40'sd45 * 40'sd16777216;
  localparam logic signed [39:0] MAG_HI  =  40'sd60 * 40'sd16777216;

  localparam logic [23:0] PRESS_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic signed [31:0] tq_a;  // avg or min temperature, q24
    logic signed [31:0] tq_b;  // max temperature, or avg in single mode, q24
    logic               mean;
    logic               buck;
    logic               oor;
  } svp_item_t;

  // floor(2^32 / i) for the series terms
  function automatic logic [32:0] recip_f(input logic [3:0] i);
    logic [32:0] r;
    case (i)
      4'd1:    r = 33'h1_0000_0000;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      4'd11:   r = 33'd390451572;
      4'd12:   r = 33'd357913941;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/svp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_front
// accepts temperature requests, scales them to q24 and picks the formula
// ----------------------------------------------------------------------------
module svp_front #(
  parameter int TEMP_FRAC_BITS = svp_pkg::TEMP_FRAC_BITS_DEF
) (
  input  logic                signed [15:0] avg_temperature_i,
  input  logic                signed [15:0] min_temperature_i,
  input  logic                signed [15:0] max_temperature_i,
  input  logic                              use_min_max_i,
  output svp_pkg::svp_item_t                item_o
);
  import svp_pkg::*;

  localparam int SHIFT = 24 - TEMP_FRAC_BITS;

  logic signed [39:0] tav, tmn, tmx;
  logic buck_av, mag_av, buck_mm, mag_mm;

  assign tav = {{24{avg_temperature_i[15]}}, avg_temperature_i} <<< SHIFT;
  assign tmn = {{24{min_temperature_i[15]}}, min_temperature_i} <<< SHIFT;
  assign tmx = {{24{max_temperature_i[15]}}, max_temperature_i} <<< SHIFT;

  assign buck_av = (tav >= BUCK_LO) && (tav <= BUCK_HI);
  assign mag_av  = (tav >= MAG_LO) && (tav <= MAG_HI);
  assign buck_mm = (tmn >= BUCK_LO) && (tmn <= BUCK_HI) && (tmx >= BUCK_LO) && (tmx <= BUCK_HI);
  assign mag_mm  = (tmn >= MAG_LO) && (tmn <= MAG_HI) && (tmx >= MAG_LO) && (tmx <= MAG_HI);

  always_comb begin
    item_o.mean = use_min_max_i;
    if (use_min_max_i) begin
      item_o.tq_a = tmn[31:0];
      item_o.tq_b = tmx[31:0];
      item_o.buck = buck_mm;
      item_o.oor  = !(buck_mm || mag_mm);
    end else begin
      item_o.tq_a = tav[31:0];
      item_o.tq_b = tav[31:0];
      item_o.buck = buck_av;
      item_o.oor  = !(buck_av || mag_av);
    end
  end

endmodule

FILE: rtl/svp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_queue
// short queue between the classifying front and the evaluating back end
// ----------------------------------------------------------------------------
module svp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  svp_pkg::svp_item_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               pop_valid_o,
  output svp_pkg::svp_item_t pop_data_o
);
  import svp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  svp_item_t          mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]     count_q, count_d;
  logic               push, pop;

  assign full_o      = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_q];
  assign push        = push_i && !full_o;
  assign pop         = pop_i && pop_valid_o;

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PTR_W+1)'(QUEUE_DEPTH)) else $error("queue count over depth");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1)) else $error("push lost");
  a_empty_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |=> (count_q == '0) || $past(push_i)) else $error("entry from nowhere");
`endif

endmodule

FILE: rtl/svp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module svp_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [svp_pkg::DIV_NUM_W-1:0]     num_i,
  input  logic [svp_pkg::DIV_DEN_W-1:0]     den_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [svp_pkg::DIV_QUO_W-1:0]     quo_o
);
  import svp_pkg::*;

  localparam int CNT_W = $clog2(DIV_QUO_W);

  logic                 busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [DIV_QUO_W-1:0] lo_q, lo_d, quo_q, quo_d;
  logic [DIV_DEN_W-1:0] trial;
  logic                 fits;

  // numerator is known to be below den * 2^DIV_QUO_W
  assign trial = {rem_q[DIV_DEN_W-2:0], lo_q[DIV_QUO_W-1]};
  assign fits  = (trial >= den_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    lo_d   = lo_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_QUO_W - 1);
      rem_d  = DIV_DEN_W'(num_i[DIV_NUM_W-1:DIV_QUO_W]);
      lo_d   = num_i[DIV_QUO_W-1:0];
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? trial - den_q : trial;
      quo_d = {quo_q[DIV_QUO_W-2:0], fits};
      lo_d  = {lo_q[DIV_QUO_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/svp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_back
// evaluates the formula per temperature: divisions, exp series, scaling
// ----------------------------------------------------------------------------
module svp_back #(
  parameter int PRESS_FRAC_BITS = svp_pkg::PRESS_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  svp_pkg::svp_item_t q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [23:0]        pressure_o,
  output logic               out_of_range_o
);
  import svp_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_LOAD = 16'h0002,
    S_MAG  = 16'h0004,
    S_DIVF = 16'h0008,
    S_DIVR = 16'h0010,
    S_BX   = 16'h0020,
    S_DIVX = 16'h0040,
    S_KDIV = 16'h0080,
    S_DIVK = 16'h0100,
    S_T1   = 16'h0200,
    S_T2   = 16'h0400,
    S_T3   = 16'h0800,
    S_SC   = 16'h1000,
    S_RND  = 16'h2000,
    S_FIN  = 16'h4000,
    S_OUT  = 16'h8000
  } back_state_e;

  localparam logic signed [7:0] SH_BASE = 8'(46 - PRESS_FRAC_BITS);

  back_state_e state_q, state_d;
  svp_item_t   item_q, item_d;
  logic        sel_q, sel_d;
  logic        out_valid_q, out_valid_d;
  logic [23:0] out_pres_q, out_pres_d, res_pres_q, res_pres_d;
  logic        out_oor_q, out_oor_d, res_oor_q, res_oor_d;

  logic signed [31:0] tq_q, tq_d, f_q, f_d, x_q, x_d;
  logic [30:0]        mag_q, mag_d, t_q, t_d, v_q, v_d;
  logic               neg_q, neg_d;
  logic [59:0]        mprod_q, mprod_d, vval;
  logic signed [60:0] bprod_q, bprod_d;
  logic [64:0]        rprod_q, rprod_d;
  logic [56:0]        kprod_q, kprod_d;
  logic [29:0]        u_q, u_d;
  logic [32:0]        s_q, s_d;
  logic [3:0]         i_q, i_d;
  logic [60:0]        p1_q, p1_d, acc_q, acc_d;
  logic [63:0]        p2_q, p2_d, pa_q, pa_d, rnd;
  logic signed [5:0]  k_q, k_d;

  // divider
  logic                 div_start, div_busy, div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_QUO_W-1:0] div_quo;

  svp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // helpers
  logic signed [31:0] tq_sel, tq_neg, x_neg, fq_s;
  logic [30:0]        mag_sel;
  logic [27:0]        x_mag, krem;
  logic signed [28:0] quo_s, qr_s;
  logic [34:0]        den_c, den_cc;
  logic [31:0]        q0;
  logic [35:0]        q0i, remi;
  logic [30:0]        tn;
  logic signed [7:0]  sh_raw;
  logic [5:0]         sh_amt;
  logic [61:0]        fin_sum;
  logic [5:0]         kq;
  logic [29:0]        kl;

  assign tq_sel  = sel_q ? item_q.tq_b : item_q.tq_a;
  assign tq_neg  = -tq_sel;
  assign mag_sel = tq_sel[31] ? tq_neg[30:0] : tq_sel[30:0];
  assign x_neg   = -x_q;
  assign x_mag   = x_q[31] ? x_neg[27:0] : x_q[27:0];
  assign quo_s   = {1'b0, div_quo};
  assign qr_s    = neg_q ? -quo_s : quo_s;
  assign den_c   = 35'(K_C) + {{3{tq_q[31]}}, tq_q};
  assign den_cc  = 35'(K_CC) + {{3{tq_q[31]}}, tq_q};

  // truncated 2t/469 with the temperature's sign
  assign fq_s = neg_q ? -$signed({8'b0, rprod_q[64:41]}) : $signed({8'b0, rprod_q[64:41]});

  // quotient and remainder of |x| by ln 2
  assign kq   = {1'b0, kprod_q[56:52]};
  assign kl   = 30'(kq) * 30'(K_LN2);
  assign krem = x_mag - kl[27:0];

  assign q0   = p2_q[63:32];
  assign q0i  = q0 * i_q;
  assign remi = {5'b0, v_q} - q0i;
  assign tn   = (remi >= {32'b0, i_q}) ? 31'(q0 + 1'b1) : q0[30:0];

  always_comb begin
    sh_raw = SH_BASE - {{2{k_q[5]}}, k_q};
    if (sh_raw < 8'sd1) begin
      sh_amt = 6'd1;
    end else if (sh_raw > 8'sd63) begin
      sh_amt = 6'd63;
    end else begin
      sh_amt = sh_raw[5:0];
    end
  end

  assign rnd     = pa_q + (64'd1 << (sh_amt - 6'd1));
  assign vval    = 60'(rnd >> sh_amt);
  assign fin_sum = item_q.mean ? ({1'b0, acc_q} + 62'd256) >> 9
                               : ({1'b0, acc_q} + 62'd128) >> 8;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    out_pres_d  = out_pres_q;
    out_oor_d   = out_oor_q;
    res_pres_d  = res_pres_q;
    res_oor_d   = res_oor_q;
    tq_d        = tq_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    f_d         = f_q;
    x_d         = x_q;
    mprod_d     = mprod_q;
    bprod_d     = bprod_q;
    rprod_d     = rprod_q;
    kprod_d     = kprod_q;
    u_d         = u_q;
    t_d         = t_q;
    s_d         = s_q;
    v_d         = v_q;
    i_d         = i_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    pa_d        = pa_q;
    k_d         = k_q;
    acc_d       = acc_q;
    q_pop_o     = 1'b0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_data_i;
          sel_d   = 1'b0;
          if (q_data_i.oor) begin
            res_pres_d = '0;
            res_oor_d  = 1'b1;
            state_d    = S_OUT;
          end else begin
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        tq_d  = tq_sel;
        mag_d = mag_sel;
        neg_d = tq_sel[31];
        if (item_q.buck) begin
          rprod_d = {mag_sel, 1'b0} * K_F_RCP;
          state_d = S_DIVF;
        end else begin
          mprod_d = K_BB * mag_sel;
          state_d = S_MAG;
        end
      end
      S_MAG: begin
        div_start = 1'b1;
        div_num   = mprod_q;
        div_den   = den_cc[DIV_DEN_W-1:0];
        state_d   = S_DIVX;
      end
      S_DIVF: begin
        f_d       = K_B - fq_s;
        div_start = 1'b1;
        div_num   = DIV_NUM_W'({mag_q, 24'b0});
        div_den   = den_c[DIV_DEN_W-1:0];
        state_d   = S_DIVR;
      end
      S_DIVR: begin
        if (div_done) begin
          bprod_d = f_q * qr_s;
          state_d = S_BX;
        end
      end
      S_BX: begin
        // floor of the product over 2^24
        x_d     = bprod_q[55:24];
        state_d = S_KDIV;
      end
      S_DIVX: begin
        if (div_done) begin
          x_d     = {{3{qr_s[28]}}, qr_s};
          state_d = S_KDIV;
        end
      end
      S_KDIV: begin
        kprod_d = x_mag * K_LN2_RCP;
        state_d = S_DIVK;
      end
      S_DIVK: begin
        // floor division by ln 2 and the reduced argument
        if (!x_q[31]) begin
          k_d = kq;
          u_d = {krem[23:0], 6'b0};
        end else if (krem != '0) begin
          k_d = -(kq + 6'd1);
          u_d = {K_LN2 - krem[23:0], 6'b0};
        end else begin
          k_d = -kq;
          u_d = '0;
        end
        t_d     = 31'h4000_0000;
        s_d     = 33'h0_4000_0000;
        i_d     = 4'd1;
        state_d = S_T1;
      end
      S_T1: begin
        p1_d    = t_q * u_q;
        state_d = S_T2;
      end
      S_T2: begin
        v_d     = p1_q[60:30];
        p2_d    = p1_q[60:30] * recip_f(i_q);
        state_d = S_T3;
      end
      S_T3: begin
        // reciprocal quotient is exact or one short
        t_d = tn;
        s_d = s_q + {2'b0, tn};
        i_d = i_q + 4'd1;
        state_d = (i_q == 4'd12) ? S_SC : S_T1;
      end
      S_SC: begin
        pa_d    = (item_q.buck ? K_A : K_AA) * s_q;
        state_d = S_RND;
      end
      S_RND: begin
        if (!sel_q) begin
          acc_d = {1'b0, vval};
          if (item_q.mean) begin
            sel_d   = 1'b1;
            state_d = S_LOAD;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          acc_d   = acc_q + {1'b0, vval};
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        res_pres_d = (fin_sum > 62'(PRESS_MAX)) ? PRESS_MAX : fin_sum[23:0];
        res_oor_d  = 1'b0;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_pres_d  = res_pres_q;
          out_oor_d   = res_oor_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    out_pres_q <= out_pres_d;
    out_oor_q  <= out_oor_d;
    res_pres_q <= res_pres_d;
    res_oor_q  <= res_oor_d;
    tq_q       <= tq_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    f_q        <= f_d;
    x_q        <= x_d;
    mprod_q    <= mprod_d;
    bprod_q    <= bprod_d;
    rprod_q    <= rprod_d;
    kprod_q    <= kprod_d;
    u_q        <= u_d;
    t_q        <= t_d;
    s_q        <= s_d;
    v_q        <= v_d;
    i_q        <= i_d;
    p1_q       <= p1_d;
    p2_q       <= p2_d;
    pa_q       <= pa_d;
    k_q        <= k_d;
    acc_q      <= acc_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pressure_o     = out_pres_q;
  assign out_of_range_o = out_oor_q;

endmodule

FILE: rtl/saturation_vapor_pressure_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturation_vapor_pressure_core
// saturation vapor pressure (q8.16 hPa) from q8.8 daily air temperatures
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_ready_o carry one request of average,
//   minimum and maximum temperature. output channel: out_valid_o /
//   out_ready_i carry pressure_o and out_of_range_o. the apb register at
//   address 0 (bit 0) selects the mean of the pressures at min and max.
// flow
//   the front classifies a request in the accept cycle and parks it in a
//   two-entry queue. the back end's time per temperature is dominated by
//   one division on the shared bit-serial divider and the 12-term exp
//   series, each term passing states T1, T2 and T3. in min/max mode both
//   temperatures are evaluated in turn; out-of-range requests skip the
//   evaluation and go straight to the output state.
//   up to two further requests are accepted while one is evaluated.
// reset
//   queue and output register empty, mode register cleared to 0.
// stall
//   a held result stays in the output register; the back end waits in its
//   output state, the queue fills, then in_ready_o drops.
module saturation_vapor_pressure_core #(
  parameter int TEMP_FRAC_BITS  = svp_pkg::TEMP_FRAC_BITS_DEF,
  parameter int PRESS_FRAC_BITS = svp_pkg::PRESS_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // apb register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] avg_temperature_i,
  input  logic signed [15:0] min_temperature_i,
  input  logic signed [15:0] max_temperature_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [23:0]        pressure_o,
  output logic               out_of_range_o
);
  import svp_pkg::*;

  logic      use_min_max_q, use_min_max_d;
  logic      cfg_write;
  svp_item_t front_item, q_item;
  logic      q_full, q_valid, q_pop;

  // register 0 is the only one; addresses with bit 2 clear alias it, the others read zero and ignore writes
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == 1'b0) ? {31'b0, use_min_max_q} : 32'b0;

  always_comb begin
    use_min_max_d = use_min_max_q;
    if (cfg_write && (paddr[2] == 1'b0)) begin
      use_min_max_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_min_max_q <= 1'b0;
    end else begin
      use_min_max_q <= use_min_max_d;
    end
  end

  // front: scale and classify in the accept cycle
  svp_front #(
    .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
  ) u_front (
    .avg_temperature_i (avg_temperature_i),
    .min_temperature_i (min_temperature_i),
    .max_temperature_i (max_temperature_i),
    .use_min_max_i     (use_min_max_q),
    .item_o            (front_item)
  );

  assign in_ready_o = !q_full;

  svp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && in_ready_o),
    .push_data_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_item)
  );

  // back end: formula evaluation and output register
  svp_back #(
    .PRESS_FRAC_BITS (PRESS_FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pressure_o     (pressure_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

FILE: tb/saturation_vapor_pressure_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturation_vapor_pressure_core_tb
// checks the vapor pressure core against a bit-exact model of the buck and
// magnus formulas in both modes, with random request and result stalls
// ----------------------------------------------------------------------------
module saturation_vapor_pressure_core_tb;
  import svp_pkg::*;

  localparam int REG_MODE   = 0;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [23:0] pressure;
    logic        oor;
  } press_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] avg_temperature_i = '0, min_temperature_i = '0;
  logic signed [15:0] max_temperature_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [23:0] pressure_o;
  logic out_of_range_o;

  // mode as the model sees it
  logic mean_mode = 1'b0;
  press_res_t pending_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int out_wait = 0;
  bit sending = 1'b0;

  always #5 clk_i = ~clk_i;

  saturation_vapor_pressure_core u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .avg_temperature_i, .min_temperature_i,
    .max_temperature_i, .out_valid_o, .out_ready_i, .pressure_o, .out_of_range_o
  );

  // floor division for signed 64 bit
  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q -= 1;
    return q;
  endfunction

  // pressure of one q24 temperature in q(press_frac+8)
  function automatic longint unsigned eval_pressure(longint tq, bit buck);
    longint x, k, r, sh, f, q;
    longint unsigned u, s, t, p;
    if (buck) begin
      f = longint'(K_B) - (tq * 2) / 469;
      q = (tq * 64'sd16777216) / (longint'(K_C) + tq);
      x = fdiv(f * q, 64'sd16777216);
    end else begin
      x = (longint'(K_BB) * tq) / (longint'(K_CC) + tq);
    end
    k = fdiv(x, longint'(K_LN2));
    r = x - k * longint'(K_LN2);
    u = longint'(r) * 64;
    s = 64'd1 << 30;
    t = 64'd1 << 30;
    for (int i = 1; i <= 12; i++) begin
      t = ((t * u) >> 30) / i;
      s += t;
    end
    p = (buck ? longint'(K_A) : longint'(K_AA)) * s;
    sh = 46 - PRESS_FRAC_BITS_DEF - k;
    if (sh < 1) sh = 1;
    if (sh > 63) sh = 63;
    return (p + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic bit within_q24(longint tq, longint lo, longint hi);
    return tq >= lo * 16777216 && tq <= hi * 16777216;
  endfunction

  function automatic press_res_t predict_pressure(logic signed [15:0] tav,
      logic signed [15:0] tmn, logic signed [15:0] tmx);
    longint qa, qn, qx;
    longint unsigned p;
    bit buck, mag;
    press_res_t res;
    qa = longint'(tav) * 65536;
    qn = longint'(tmn) * 65536;
    qx = longint'(tmx) * 65536;
    p = 0;
    res.oor = 1'b0;
    if (mean_mode) begin
      buck = within_q24(qn, -80, 50) && within_q24(qx, -80, 50);
      mag = within_q24(qn, -45, 60) && within_q24(qx, -45, 60);
      if (buck || mag)
        p = (eval_pressure(qn, buck) + eval_pressure(qx, buck) + 256) >> 9;
      else res.oor = 1'b1;
    end else begin
      buck = within_q24(qa, -80, 50);
      mag = within_q24(qa, -45, 60);
      if (buck || mag) p = (eval_pressure(qa, buck) + 128) >> 8;
      else res.oor = 1'b1;
    end
    if (p > 64'hFFFFFF) p = 64'hFFFFFF;
    res.pressure = p[23:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // apb write: setup then access
  task automatic write_mode(logic val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * REG_MODE); pwdata <= {31'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mean_mode = val;
  endtask

  // drop the request line and drain
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic send_request(logic signed [15:0] tav, logic signed [15:0] tmn,
      logic signed [15:0] tmx, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19));
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    avg_temperature_i <= tav;
    min_temperature_i <= tmn;
    max_temperature_i <= tmx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_q.push_back(predict_pressure(tav, tmn, tmx));
  endtask

  // result stalls: out_ready_i is held low for a random wait drawn for every result
  always @(posedge clk_i) begin
    int wait_n;
    if (out_valid_o && out_ready_i) begin
      wait_n = $urandom_range(0, 19);
      out_wait <= wait_n;
      out_ready_i <= (wait_n == 0);
    end else if (out_wait != 0) begin
      out_wait <= out_wait - 1;
      out_ready_i <= (out_wait == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result check
  always @(posedge clk_i) begin
    press_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", pressure_o, -1);
      end else begin
        want = pending_q.pop_front();
        if (pressure_o !== want.pressure)
          report_mismatch("pressure", pressure_o, want.pressure);
        if (out_of_range_o !== want.oor)
          report_mismatch("out_of_range", out_of_range_o, want.oor);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      idle_cycles <= 0;
    else if (sending || pending_q.size() != 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("saturation_vapor_pressure_core_tb failed");
      $finish;
    end
  end

  // edges of both formula ranges, single mode
  task automatic test_single_edges();
    logic signed [15:0] pts[$];
    pts = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd20480, -16'sd20481, 16'sd12800,
            16'sd12801, -16'sd11520, -16'sd11521, 16'sd15360, 16'sd15361, 16'sd1,
            -16'sd1, 16'sd6400};
    write_mode(1'b0);
    foreach (pts[i]) send_request(pts[i], 16'($urandom), 16'($urandom));
    wait_idle();
  endtask

  // mean mode: mixed ranges, swapped order
  task automatic test_mean_edges();
    write_mode(1'b1);
    send_request(16'sd0, -16'sd20480, 16'sd12800);
    send_request(16'sd0, 16'sd12800, -16'sd20480);
    send_request(16'sd0, -16'sd11520, 16'sd15360);
    send_request(16'sd0, 16'sd15360, -16'sd11520);
    send_request(16'sd0, -16'sd20480, 16'sd15360);
    send_request(16'sd0, 16'sh8000, 16'sh7FFF);
    send_request(16'sd0, 16'sd15361, 16'sd0);
    send_request(16'sd0, 16'sd0, 16'sd0);
    send_request(16'sd0, 16'sd2560, 16'sd7680);
    wait_idle();
  endtask

  function automatic logic signed [15:0] rand_temp();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($signed($urandom_range(0, 32000)) - 16000);
      default: return 16'($signed($urandom_range(0, 35000)) - 20000);
    endcase
  endfunction

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_request(rand_temp(), rand_temp(), rand_temp(), $urandom_range(0, 9) == 0);
  endtask

  task automatic test_random_modes();
    write_mode(1'b0); test_random(300); wait_idle();
    write_mode(1'b1); test_random(300); wait_idle();
    write_mode(1'b0); test_random(300); wait_idle();
    write_mode(1'b1); test_random(300); wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sending = 1'b1;
    test_single_edges();
    test_mean_edges();
    test_random_modes();
    sending = 1'b0;
    if (errors == 0) $display("saturation_vapor_pressure_core_tb passed");
    else $display("saturation_vapor_pressure_core_tb failed");
    $finish;
  end

endmodule
